FILE: src/twqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twqp_pkg
// shared constants and types of the ternary weight quantizer and packer
// ----------------------------------------------------------------------------
package twqp_pkg;
    localparam logic [30:0] TINY_MAG_MAX  = 31'h358637BD;
    localparam logic [30:0] NAN_MAG_FLOOR = 31'h7F800001;
    localparam logic [1:0]  CODE_NEG  = 2'd0;
    localparam logic [1:0]  CODE_ZERO = 2'd1;
    localparam logic [1:0]  CODE_POS  = 2'd2;

    typedef struct packed {
        logic       is_scale;
        logic [7:0] packed_byte;
        logic [31:0] scale_bits;
        logic       last_out;
    } t_result;

    typedef struct packed {
        logic [31:0] weight_bits;
        logic        end_of_tensor;
    } t_item;
endpackage

FILE: src/twqp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twqp_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface twqp_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/twqp_code.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twqp_code
// classifies one weight into a 2-bit code and a max candidate
// ----------------------------------------------------------------------------
module twqp_code
    import twqp_pkg::*;
(
    input  logic [31:0] i_bits,
    output logic [1:0]  o_code,
    output logic        o_valid_mag,
    output logic [30:0] o_mag
);
    always_comb begin
        o_mag       = i_bits[30:0];
        o_valid_mag = (o_mag < NAN_MAG_FLOOR);
        if (!o_valid_mag) begin
            o_code = CODE_NEG;
        end else if (o_mag <= TINY_MAG_MAX) begin
            o_code = CODE_ZERO;
        end else if (i_bits[31]) begin
            o_code = CODE_NEG;
        end else begin
            o_code = CODE_POS;
        end
    end
endmodule

FILE: src/ternary_weight_quantize_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_weight_quantize_pack
// quantizes float weights to ternary 2-bit codes and packs blocks into bytes
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_in     in   weight_bits[31:0], end_of_tensor
// m_out    out  is_scale, packed_byte[7:0], scale_bits[31:0], last_out
//
// an ordinary weight goes through memory read, then or-in and write back
// the block-completing weight adds a read-ahead state and a drain of
// BLOCK_ELEMS/4 bytes, one a cycle while the output is not stalled, through the single
// read port of the pack memory, each cleared as it is read
// end of tensor adds one scale transaction, then a clearing pass over all
// BLOCK_ELEMS/4 bytes of the pack memory before the next weight is taken
// reset clears control state and runs the same clearing pass
// a stalled output holds the drain and scale steps; an output register parts the sides
// ----------------------------------------------------------------------------
module ternary_weight_quantize_pack
    import twqp_pkg::*;
#(
    parameter int BLOCK_ELEMS = 128
)(
    input  logic i_clk,
    input  logic i_rst_n,
    twqp_if.sink   s_in,
    twqp_if.source m_out
);
    localparam int NB = BLOCK_ELEMS / 4;
    localparam int AW = (NB > 1) ? $clog2(NB) : 1;
    localparam int PW = $clog2(BLOCK_ELEMS);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MOD, S_DRAIN_RD, S_DRAIN, S_SCALE} t_state;

    t_state       r_state;
    logic [7:0]   r_mem [NB];
    logic [7:0]   r_rdata;
    logic [PW-1:0] r_pos;
    logic [AW-1:0] r_bidx;
    logic [1:0]   r_grp;
    logic [30:0]  r_max;
    logic [AW-1:0] r_addr;
    logic [1:0]   r_code;
    logic         r_end;
    logic         r_oval;
    t_result      r_out;

    logic [1:0]   w_code;
    logic         w_vmag;
    logic [30:0]  w_mag;
    t_item        w_in;
    logic         w_oready;
    logic         w_load;
    logic         w_mwe;
    logic [AW-1:0] w_maddr;
    logic [7:0]   w_mwdata;
    logic [AW-1:0] w_raddr;

    assign w_in     = s_in.data;
    assign w_oready = !r_oval || m_out.ready;
    assign w_load   = w_oready && (r_state inside {S_DRAIN, S_SCALE});
    assign s_in.ready = (r_state == S_IDLE);
    assign m_out.valid = r_oval;
    assign m_out.data  = r_out;

    twqp_code u_code (.i_bits(w_in.weight_bits), .o_code(w_code),
                      .o_valid_mag(w_vmag), .o_mag(w_mag));

    // single write port: clear sweep, modify write back, or clear on drain
    always_comb begin
        w_mwe = 1'b0;
        w_maddr = r_addr;
        w_mwdata = 8'd0;
        w_raddr = r_addr;
        case (r_state)
            S_CLEAR: w_mwe = 1'b1;
            S_IDLE:  w_raddr = r_bidx;
            S_MOD: begin
                w_mwe = 1'b1;
                w_mwdata = r_rdata | (8'(r_code) << (3'd6 - {r_grp, 1'b0}));
            end
            S_DRAIN: begin
                w_mwe = w_oready;
                w_raddr = (w_oready && r_addr != AW'(NB - 1)) ? r_addr + 1'b1 : r_addr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mwe) r_mem[w_maddr] <= w_mwdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_pos   <= '0;
            r_bidx  <= '0;
            r_grp   <= '0;
            r_max   <= '0;
            r_oval  <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            if (w_load) r_oval <= 1'b1;
            else if (m_out.ready) r_oval <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    if (r_addr == AW'(NB - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_in.valid) begin
                        r_code <= w_code;
                        r_end  <= w_in.end_of_tensor;
                        r_addr <= r_bidx;
                        if (w_vmag && w_mag > r_max) r_max <= w_mag;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_pos == PW'(BLOCK_ELEMS - 1)) begin
                        r_pos   <= '0;
                        r_bidx  <= '0;
                        r_grp   <= '0;
                        r_addr  <= '0;
                        r_state <= S_DRAIN_RD;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        // byte index wraps per group, group stops at the last one
                        if (r_bidx == AW'(NB - 1)) begin
                            r_bidx <= '0;
                            if (r_grp != 2'd3) r_grp <= r_grp + 1'b1;
                        end else begin
                            r_bidx <= r_bidx + 1'b1;
                        end
                        r_state <= r_end ? S_SCALE : S_IDLE;
                    end
                end
                S_DRAIN_RD: r_state <= S_DRAIN;
                S_DRAIN: begin
                    if (w_oready) begin
                        r_out  <= '{1'b0, r_rdata, 32'd0,
                                    !r_end && r_addr == AW'(NB - 1)};
                        if (r_addr == AW'(NB - 1)) begin
                            r_addr  <= '0;
                            r_state <= r_end ? S_SCALE : S_IDLE;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                end
                S_SCALE: begin
                    if (w_oready) begin
                        r_out   <= '{1'b1, 8'd0, {1'b0, r_max}, 1'b1};
                        r_max   <= '0;
                        r_pos   <= '0;
                        r_bidx  <= '0;
                        r_grp   <= '0;
                        r_addr  <= '0;
                        // partial block dropped: sweep memory back to zero
                        r_state <= S_CLEAR;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end
endmodule

FILE: src/twqp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twqp_checker
// port-level checks of the quantizer and packer
// ----------------------------------------------------------------------------
module twqp_checker
    import twqp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [41:0] i_out_data
);
    t_result w_res;
    assign w_res = i_out_data;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output changed under stall");
    a_scale_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && w_res.is_scale |-> w_res.last_out && !w_res.scale_bits[31]
            && w_res.packed_byte == 8'd0)
        else $error("bad scale transaction");
    a_byte_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !w_res.is_scale |-> w_res.scale_bits == 32'd0)
        else $error("byte transaction carries scale");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("accepted back to back");
endmodule

bind ternary_weight_quantize_pack twqp_checker u_twqp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready),
    .i_out_data(m_out.data)
);
